// ===== src/glyph_alpha_premultiply_blend_assert.svh =====
// Assertion macros for the glyph alpha premultiply blend block
`ifndef GLYPH_ALPHA_PREMULTIPLY_BLEND_ASSERT_SVH
`define GLYPH_ALPHA_PREMULTIPLY_BLEND_ASSERT_SVH

// same-cycle implication
`define GAPB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gapb assertion failed");

// next-cycle implication
`define GAPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gapb assertion failed");

`endif

// ===== src/gapb_pkg.sv =====
// Types, register codes, alpha curve and rounding helper for the glyph blend block
`timescale 1ns / 1ps

package gapb_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_PEN_RGB          = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEN_ALPHA        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ENABLE    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_INTENSITY = 2'd3;

    localparam logic [1:0] MODE_ARGB    = 2'd0;
    localparam logic [1:0] MODE_FLIPPED = 2'd1;
    localparam logic [1:0] MODE_GRAY    = 2'd2;
    localparam logic [1:0] MODE_UNSUP   = 2'd3;

    localparam logic [7:0] PEN_ALPHA_RESET = 8'hff;
    localparam logic [16:0] ROUND_HALF     = 17'd128;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] glyph_sample;
        logic [31:0] surface_pixel;
    } sample_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        pixel_written;
    } result_t;

    typedef struct packed {
        logic [23:0] pen_rgb;
        logic [7:0]  pen_alpha;
        logic        filter_enable;
        logic [7:0]  filter_intensity;
    } cfg_t;

    localparam logic [7:0] ALPHA_CURVE [256] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02,
        8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h04, 8'h04,
        8'h04, 8'h04, 8'h04, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05,
        8'h06, 8'h06, 8'h06, 8'h07, 8'h07, 8'h07, 8'h08, 8'h08,
        8'h09, 8'h09, 8'h09, 8'h0a, 8'h0a, 8'h0a, 8'h0b, 8'h0b,
        8'h0c, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h0f, 8'h10, 8'h11,
        8'h12, 8'h12, 8'h13, 8'h14, 8'h15, 8'h15, 8'h16, 8'h17,
        8'h18, 8'h18, 8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h1d, 8'h1e,
        8'h1f, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25,
        8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d,
        8'h2f, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3d, 8'h3e, 8'h3f, 8'h40,
        8'h42, 8'h43, 8'h44, 8'h45, 8'h47, 8'h48, 8'h49, 8'h4a,
        8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52, 8'h53,
        8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a, 8'h5b, 8'h5c,
        8'h5e, 8'h5f, 8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65,
        8'h67, 8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e,
        8'h70, 8'h71, 8'h73, 8'h74, 8'h76, 8'h77, 8'h79, 8'h7a,
        8'h7c, 8'h7d, 8'h7f, 8'h80, 8'h82, 8'h83, 8'h85, 8'h86,
        8'h88, 8'h89, 8'h8a, 8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f,
        8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98,
        8'h9a, 8'h9b, 8'h9c, 8'h9e, 8'h9f, 8'ha0, 8'ha2, 8'ha3,
        8'ha5, 8'ha6, 8'ha7, 8'ha9, 8'haa, 8'hab, 8'had, 8'hae,
        8'hb0, 8'hb1, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7,
        8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'hbe, 8'hbf, 8'hc0,
        8'hc2, 8'hc3, 8'hc4, 8'hc6, 8'hc7, 8'hc8, 8'hca, 8'hcb,
        8'hcd, 8'hce, 8'hcf, 8'hd1, 8'hd2, 8'hd3, 8'hd5, 8'hd6,
        8'hd8, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hdf, 8'he0,
        8'he1, 8'he2, 8'he3, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9,
        8'heb, 8'hec, 8'hed, 8'hee, 8'hf0, 8'hf1, 8'hf2, 8'hf3,
        8'hf5, 8'hf6, 8'hf7, 8'hf9, 8'hfb, 8'hfc, 8'hff, 8'hff
    };

    // rounded divide by 255 of an 8x8 product
    function automatic logic [7:0] div255_round(input logic [15:0] prod);
        logic [16:0] v;
        logic [16:0] s;
        v = {1'b0, prod} + ROUND_HALF;
        s = v + {8'd0, v[16:8]};
        return s[15:8];
    endfunction

endpackage

// ===== src/gapb_cfg.sv =====
// Configuration register file for the glyph blend block
`timescale 1ns / 1ps

module gapb_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gapb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gapb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output gapb_pkg::cfg_t                     cfg
);
    import gapb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PEN_RGB:          cfg_next.pen_rgb          = cfg_data[23:0];
                CFG_PEN_ALPHA:        cfg_next.pen_alpha        = cfg_data[7:0];
                CFG_FILTER_ENABLE:    cfg_next.filter_enable    = cfg_data[0];
                CFG_FILTER_INTENSITY: cfg_next.filter_intensity = cfg_data[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pen_rgb          <= '0;
            cfg_reg.pen_alpha        <= PEN_ALPHA_RESET;
            cfg_reg.filter_enable    <= 1'b0;
            cfg_reg.filter_intensity <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/glyph_alpha_premultiply_blend.sv =====
// Top level: six-stage glyph coverage blend with pen color and premultiplied output
//
//   channel   signals                              direction  width
//   sample    sample_valid, sample_stall, sample   in         66
//   result    result_valid, result_stall, result   out        33
//   cfg       cfg_valid, cfg_ready, cfg_index/data in         2 + 24
//
// One request enters per cycle while sample_stall is low; each request passes
// through the stage chain: input, coverage multiply, divide and OR, curve lookup,
// channel multiplies, divide and pack into the output register.
// Reset clears all stage valid bits and loads register defaults (pen alpha 255).
// A stall on the result side holds only full stages; empty stages keep filling.
`timescale 1ns / 1ps
`include "glyph_alpha_premultiply_blend_assert.svh"

module glyph_alpha_premultiply_blend (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  gapb_pkg::sample_t                 sample,
    output logic                              result_valid,
    input  logic                              result_stall,
    output gapb_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gapb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gapb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gapb_pkg::*;

    cfg_t cfg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5, en6;

    sample_t     s1_req_reg;
    logic [15:0] s2_prod_reg;
    logic [31:0] s2_surface_reg;
    logic        s2_unsup_reg;
    logic [7:0]  s3_alpha_reg;
    logic [31:0] s3_surface_reg;
    logic        s3_unsup_reg;
    logic [7:0]  s4_alpha_reg;
    logic [31:0] s4_surface_reg;
    logic        s4_pass_reg;
    logic [15:0] s5_r_prod_reg, s5_g_prod_reg, s5_b_prod_reg;
    logic [7:0]  s5_alpha_reg;
    logic [31:0] s5_surface_reg;
    logic        s5_pass_reg;
    result_t     result_reg;

    logic [7:0]  cov;
    logic [15:0] s2_prod_next;
    logic [7:0]  s3_alpha_next;
    logic [7:0]  pen_r, pen_g, pen_b;
    logic        dark;
    logic [7:0]  s4_alpha_next;
    logic        s4_pass_next;
    result_t     result_next;

    gapb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign en6 = !out_valid_reg || !result_stall;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign sample_stall = !en1;
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    assign pen_r = cfg.pen_rgb[23:16];
    assign pen_g = cfg.pen_rgb[15:8];
    assign pen_b = cfg.pen_rgb[7:0];
    assign dark  = (pen_r <= cfg.filter_intensity) || (pen_g <= cfg.filter_intensity)
                || (pen_b <= cfg.filter_intensity);

    always_comb
    begin
        cov = (s1_req_reg.mode == MODE_ARGB) ? s1_req_reg.glyph_sample[31:24]
                                             : s1_req_reg.glyph_sample[7:0];
        s2_prod_next  = {8'd0, cfg.pen_alpha} * {8'd0, cov};
        s3_alpha_next = div255_round(s2_prod_reg) | s2_surface_reg[31:24];
        s4_alpha_next = (cfg.filter_enable && dark) ? ALPHA_CURVE[s3_alpha_reg]
                                                    : s3_alpha_reg;
        s4_pass_next  = s3_unsup_reg || (s3_alpha_reg == 8'd0);
        if (s5_pass_reg)
        begin
            result_next.pixel_out     = s5_surface_reg;
            result_next.pixel_written = 1'b0;
        end
        else
        begin
            result_next.pixel_out     = {s5_alpha_reg, div255_round(s5_r_prod_reg),
                                         div255_round(s5_g_prod_reg),
                                         div255_round(s5_b_prod_reg)};
            result_next.pixel_written = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= sample_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_req_reg <= sample;
        end
        if (en2)
        begin
            s2_prod_reg    <= s2_prod_next;
            s2_surface_reg <= s1_req_reg.surface_pixel;
            s2_unsup_reg   <= (s1_req_reg.mode == MODE_UNSUP);
        end
        if (en3)
        begin
            s3_alpha_reg   <= s3_alpha_next;
            s3_surface_reg <= s2_surface_reg;
            s3_unsup_reg   <= s2_unsup_reg;
        end
        if (en4)
        begin
            s4_alpha_reg   <= s4_alpha_next;
            s4_surface_reg <= s3_surface_reg;
            s4_pass_reg    <= s4_pass_next;
        end
        if (en5)
        begin
            s5_r_prod_reg  <= {8'd0, pen_r} * {8'd0, s4_alpha_reg};
            s5_g_prod_reg  <= {8'd0, pen_g} * {8'd0, s4_alpha_reg};
            s5_b_prod_reg  <= {8'd0, pen_b} * {8'd0, s4_alpha_reg};
            s5_alpha_reg   <= s4_alpha_reg;
            s5_surface_reg <= s4_surface_reg;
            s5_pass_reg    <= s4_pass_reg;
        end
        if (en6)
        begin
            result_reg <= result_next;
        end
    end

    `GAPB_ASSERT_IMPL(a_empty_out_no_stall, clk, rst_n, !out_valid_reg, !sample_stall)
    `GAPB_ASSERT_NEXT(a_stage1_hold, clk, rst_n, v1_reg && !en2,
                      v1_reg && $stable(s1_req_reg))
    `GAPB_ASSERT_IMPL(a_written_alpha_nonzero, clk, rst_n,
                      out_valid_reg && result_reg.pixel_written && !cfg.filter_enable,
                      result_reg.pixel_out[31:24] != 8'd0)

endmodule
